[hdl/asmfs_pkg.sv]
// Shared constants, register codes and types for the ASM frame synchronizer.
package asmfs_pkg;

  // Codeword geometry and marker length.
  localparam int BLOCK_BYTES = 255;
  localparam int MAX_DEPTH   = 8;
  localparam int MARKER_BITS = 32;

  // Field widths of the channels.
  localparam int PATTERN_W = 32;
  localparam int ERR_W     = 6;
  localparam int DEPTH_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int BLOCK_W   = 3;
  localparam int POS_W     = 8;

  // Internal counter widths.
  localparam int COUNT_W   = $clog2(BLOCK_BYTES * MAX_DEPTH);
  localparam int ONES_W    = $clog2(MARKER_BITS + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BIT_ERRORS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVED_ORDER = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PATTERN_W-1:0] SYNC_PATTERN_RESET = 32'h1ACF_FC1D;
  localparam logic [ERR_W-1:0]     MAX_ERRORS_RESET   = '0;
  localparam logic [DEPTH_W-1:0]   DEPTH_RESET        = 4'd1;
  localparam logic                 ORDER_RESET        = 1'b1;

  // Codeword counters that the mapper advances on each finished byte.
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [BLOCK_W-1:0] block_count;
    logic [POS_W-1:0]   position_count;
  } frame_count_t;

  // Mapper result for the byte now finishing.
  typedef struct packed {
    logic [BLOCK_W-1:0] block_index;
    logic [POS_W-1:0]   byte_position;
    logic               frame_last;
    frame_count_t       count_next;
  } byte_map_t;

endpackage

[hdl/asmfs_if.sv]
// Channel interfaces: received bits, mapped bytes and configuration writes.
interface asmfs_bit_if;
  logic valid;
  logic ready;
  logic rx_bit;

  modport source (output valid, output rx_bit, input ready);
  modport sink (input valid, input rx_bit, output ready);
  modport monitor (input valid, input rx_bit, input ready);
endinterface

interface asmfs_byte_if;
  logic                          valid;
  logic                          ready;
  logic [asmfs_pkg::BYTE_W-1:0]  byte_value;
  logic [asmfs_pkg::BLOCK_W-1:0] block_index;
  logic [asmfs_pkg::POS_W-1:0]   byte_position;
  logic                          frame_last;

  modport source (output valid, output byte_value, output block_index,
                  output byte_position, output frame_last, input ready);
  modport sink (input valid, input byte_value, input block_index,
                input byte_position, input frame_last, output ready);
  modport monitor (input valid, input byte_value, input block_index,
                   input byte_position, input frame_last, input ready);
endinterface

interface asmfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [asmfs_pkg::CFG_IDX_W-1:0] index;
  logic [asmfs_pkg::PATTERN_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
  modport monitor (input valid, input index, input data, input ready);
endinterface

[hdl/asmfs_sync_detect.sv]
// Marker detector: Hamming distance of the shifted window against the marker.
module asmfs_sync_detect (
  input  logic [asmfs_pkg::MARKER_BITS-1:0] window,
  input  logic [asmfs_pkg::PATTERN_W-1:0]   sync_pattern,
  input  logic [asmfs_pkg::ERR_W-1:0]       max_bit_errors,
  output logic                              match
);

  localparam int GROUPS = (asmfs_pkg::MARKER_BITS + 7) / 8;

  logic [GROUPS*8-1:0]             diff;
  logic [GROUPS-1:0][3:0]          group_ones;
  logic [asmfs_pkg::ONES_W-1:0]    ones;

  // Mismatch bits, padded with zeros up to whole bytes.
  always_comb begin
    diff = '0;
    diff[asmfs_pkg::MARKER_BITS-1:0] =
      window ^ sync_pattern[asmfs_pkg::MARKER_BITS-1:0];
  end

  // Count ones per byte, then add the byte counts.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_ones[g] = '0;
      for (int b = 0; b < 8; b++) begin
        group_ones[g] = group_ones[g] + 4'(diff[g*8+b]);
      end
    end
    ones = '0;
    for (int g = 0; g < GROUPS; g++) begin
      ones = ones + asmfs_pkg::ONES_W'(group_ones[g]);
    end
  end

  // Sync when the distance is within the accepted error count.
  assign match = (asmfs_pkg::ERR_W'(ones) <= max_bit_errors);

endmodule

[hdl/asmfs_byte_map.sv]
// Byte mapper: RS block and position of the finishing byte, and the next counts.
module asmfs_byte_map (
  input  logic [asmfs_pkg::DEPTH_W-1:0] interleave_depth,
  input  logic                          interleaved_order,
  input  asmfs_pkg::frame_count_t       count,
  output asmfs_pkg::byte_map_t          map
);

  logic [asmfs_pkg::DEPTH_W-1:0] depth;
  logic [asmfs_pkg::COUNT_W-1:0] last_index;
  logic [asmfs_pkg::DEPTH_W-1:0] block_inc;
  logic [asmfs_pkg::POS_W:0]     pos_inc;

  // Depth zero counts as one, depths past the maximum are clipped.
  always_comb begin
    depth = interleave_depth;
    if (depth == '0) begin
      depth = asmfs_pkg::DEPTH_W'(1);
    end
    if (depth > asmfs_pkg::DEPTH_W'(asmfs_pkg::MAX_DEPTH)) begin
      depth = asmfs_pkg::DEPTH_W'(asmfs_pkg::MAX_DEPTH);
    end
  end

  // Index of the final byte of the codeword.
  assign last_index = asmfs_pkg::COUNT_W'(asmfs_pkg::BLOCK_BYTES) *
                      asmfs_pkg::COUNT_W'(depth) - asmfs_pkg::COUNT_W'(1);

  assign block_inc = asmfs_pkg::DEPTH_W'(count.block_count) + asmfs_pkg::DEPTH_W'(1);
  assign pos_inc   = {1'b0, count.position_count} + (asmfs_pkg::POS_W+1)'(1);

  // Current labels and the counts for the following byte.
  always_comb begin
    map.block_index   = count.block_count;
    map.byte_position = count.position_count;
    map.frame_last    = (count.byte_count >= last_index);
    map.count_next.byte_count = count.byte_count + asmfs_pkg::COUNT_W'(1);
    if (interleaved_order) begin
      if (block_inc >= depth) begin
        map.count_next.block_count    = '0;
        map.count_next.position_count = pos_inc[asmfs_pkg::POS_W-1:0];
      end else begin
        map.count_next.block_count    = block_inc[asmfs_pkg::BLOCK_W-1:0];
        map.count_next.position_count = count.position_count;
      end
    end else begin
      if (pos_inc >= (asmfs_pkg::POS_W+1)'(asmfs_pkg::BLOCK_BYTES)) begin
        map.count_next.position_count = '0;
        map.count_next.block_count    = block_inc[asmfs_pkg::BLOCK_W-1:0];
      end else begin
        map.count_next.position_count = pos_inc[asmfs_pkg::POS_W-1:0];
        map.count_next.block_count    = count.block_count;
      end
    end
  end

endmodule

[hdl/asm_frame_sync_deinterleaver.sv]
// Top level of the ASM frame synchronizer and RS byte deinterleaver.
//
// Channels: bits takes one received bit per request; bytes returns one
// request for every eighth bit once sync is found, carrying the byte (first
// bit in the MSB), its RS block index, its position in that block and a
// last flag on the final byte of the codeword. cfg writes the sync pattern,
// the error threshold, the interleave depth and the mapping order; it is
// always ready and should be used only while the block is idle.
// Throughput: one bit per clock while bits.ready is high. The state registers
// update on the edge that accepts a bit, and the byte request is valid from
// the next cycle on after the accepting edge of its eighth bit.
// Stall: the result register holds the byte while bytes.ready is low; bits
// keeps taking requests unless that register is full and not being drained
// in the same cycle.
// Reset: search mode, cleared shift register and counters, no pending
// result, configuration back to its defaults.
module asm_frame_sync_deinterleaver (
  input  logic                clk,
  input  logic                rst,
  asmfs_bit_if.sink           bits,
  asmfs_byte_if.source        bytes,
  asmfs_cfg_if.sink           cfg
);

  // Configuration registers.
  logic [asmfs_pkg::PATTERN_W-1:0]   sync_pattern;
  logic [asmfs_pkg::ERR_W-1:0]       max_bit_errors;
  logic [asmfs_pkg::DEPTH_W-1:0]     interleave_depth;
  logic                              interleaved_order;

  // Frame state.
  logic                              in_frame;
  logic [asmfs_pkg::MARKER_BITS-1:0] shift_reg;
  logic [2:0]                        bit_count;
  asmfs_pkg::frame_count_t           count;

  logic [asmfs_pkg::MARKER_BITS-1:0] shift_next;
  logic                              match;
  logic                              accept;
  logic                              byte_done;
  asmfs_pkg::byte_map_t              map;

  assign cfg.ready = 1'b1;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern      <= asmfs_pkg::SYNC_PATTERN_RESET;
      max_bit_errors    <= asmfs_pkg::MAX_ERRORS_RESET;
      interleave_depth  <= asmfs_pkg::DEPTH_RESET;
      interleaved_order <= asmfs_pkg::ORDER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        asmfs_pkg::REG_SYNC_PATTERN:      sync_pattern <= cfg.data;
        asmfs_pkg::REG_MAX_BIT_ERRORS:    max_bit_errors <= cfg.data[asmfs_pkg::ERR_W-1:0];
        asmfs_pkg::REG_INTERLEAVE_DEPTH:  interleave_depth <= cfg.data[asmfs_pkg::DEPTH_W-1:0];
        asmfs_pkg::REG_INTERLEAVED_ORDER: interleaved_order <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // A bit is taken unless a finished byte is stuck in the result register.
  assign bits.ready = !bytes.valid || bytes.ready;
  assign accept     = bits.valid && bits.ready;
  assign shift_next = {shift_reg[asmfs_pkg::MARKER_BITS-2:0], bits.rx_bit};
  assign byte_done  = in_frame && (bit_count == 3'd7);

  asmfs_sync_detect u_sync_detect (
    .window         (shift_next),
    .sync_pattern   (sync_pattern),
    .max_bit_errors (max_bit_errors),
    .match          (match)
  );

  asmfs_byte_map u_byte_map (
    .interleave_depth  (interleave_depth),
    .interleaved_order (interleaved_order),
    .count             (count),
    .map               (map)
  );

  // Search, sync and byte assembly state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      shift_reg <= '0;
      bit_count <= '0;
      count     <= '0;
    end else if (accept) begin
      shift_reg <= shift_next;
      if (!in_frame) begin
        if (match) begin
          in_frame  <= 1'b1;
          bit_count <= '0;
          count     <= '0;
        end
      end else begin
        bit_count <= bit_count + 3'd1;
        if (byte_done) begin
          if (map.frame_last) begin
            in_frame  <= 1'b0;
            shift_reg <= '0;
            bit_count <= '0;
            count     <= '0;
          end else begin
            count <= map.count_next;
          end
        end
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes.valid <= 1'b0;
    end else if (accept && byte_done) begin
      bytes.valid <= 1'b1;
    end else if (bytes.ready) begin
      bytes.valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept && byte_done) begin
      bytes.byte_value    <= shift_next[asmfs_pkg::BYTE_W-1:0];
      bytes.block_index   <= map.block_index;
      bytes.byte_position <= map.byte_position;
      bytes.frame_last    <= map.frame_last;
    end
  end

endmodule

[hdl/asmfs_checker.sv]
// Port checker for the frame synchronizer, bound to the top level.
module asmfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          bits_valid,
  input logic                          bits_ready,
  input logic                          bytes_valid,
  input logic                          bytes_ready,
  input logic [asmfs_pkg::BYTE_W-1:0]  byte_value,
  input logic [asmfs_pkg::BLOCK_W-1:0] block_index,
  input logic [asmfs_pkg::POS_W-1:0]   byte_position,
  input logic                          frame_last,
  input logic                          cfg_ready
);

  // A stalled byte request keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    bytes_valid && !bytes_ready |=>
      $stable(byte_value) && $stable(block_index) &&
      $stable(byte_position) && $stable(frame_last))
    else $error("byte payload changed while stalled");

  // Bits are refused only while a byte waits on a stalled receiver.
  assert property (@(posedge clk) disable iff (rst)
    !bits_ready |-> bytes_valid && !bytes_ready)
    else $error("bit channel stalled without a pending byte");

  // A new byte request follows an accepted bit.
  assert property (@(posedge clk) disable iff (rst)
    bytes_valid && !$past(bytes_valid && !bytes_ready) |->
      $past(bits_valid && bits_ready))
    else $error("byte request without an accepted bit");

  // Reset leaves no pending byte and an always ready config port.
  assert property (@(posedge clk)
    rst |=> !bytes_valid && cfg_ready)
    else $error("state after reset is wrong");

endmodule

bind asm_frame_sync_deinterleaver asmfs_checker u_asmfs_checker (
  .clk           (clk),
  .rst           (rst),
  .bits_valid    (bits.valid),
  .bits_ready    (bits.ready),
  .bytes_valid   (bytes.valid),
  .bytes_ready   (bytes.ready),
  .byte_value    (bytes.byte_value),
  .block_index   (bytes.block_index),
  .byte_position (bytes.byte_position),
  .frame_last    (bytes.frame_last),
  .cfg_ready     (cfg.ready)
);

[sim/tb_top.sv]
// Testbench for the ASM frame synchronizer: directed bit table and random bit streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_N       = 26;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 40;

  // One mapped codeword byte as it leaves the block.
  typedef struct packed {
    logic [asmfs_pkg::BYTE_W-1:0]  value;
    logic [asmfs_pkg::BLOCK_W-1:0] block;
    logic [asmfs_pkg::POS_W-1:0]   pos;
    logic                          last;
  } mapped_byte_t;

  // Directed row: the bit to send and, where obvious, the byte it completes.
  typedef struct packed {
    logic         rx;
    logic         typed;
    mapped_byte_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  asmfs_bit_if  bit_ch();
  asmfs_byte_if byte_ch();
  asmfs_cfg_if  cfg_ch();

  asm_frame_sync_deinterleaver uut (
    .clk   (clk),
    .rst   (rst),
    .bits  (bit_ch),
    .bytes (byte_ch),
    .cfg   (cfg_ch)
  );

  always #1 clk = ~clk;

  // Marker 0x01 syncs on a single one after reset; then three bytes follow.
  dir_row_t directed_rows [DIR_N] = '{
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b1, '{8'hA5, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b1, '{8'hFF, 3'd0, 8'd1, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b0, '{8'h00, 3'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b1, '{8'h00, 3'd0, 8'd2, 1'b0}}
  };

  // Configuration copy, kept in step with the writes the block accepts.
  logic [asmfs_pkg::PATTERN_W-1:0]   p_pattern = asmfs_pkg::SYNC_PATTERN_RESET;
  logic [asmfs_pkg::ERR_W-1:0]       p_max_err = asmfs_pkg::MAX_ERRORS_RESET;
  logic [asmfs_pkg::DEPTH_W-1:0]     p_depth   = asmfs_pkg::DEPTH_RESET;
  logic                              p_order   = asmfs_pkg::ORDER_RESET;

  // Synchronizer and mapper state.
  logic                              s_in_frame = 1'b0;
  logic [asmfs_pkg::MARKER_BITS-1:0] s_shreg    = '0;
  logic [2:0]                        s_bitcnt   = '0;
  logic [10:0]                       s_bytecnt  = '0;
  logic [asmfs_pkg::BLOCK_W-1:0]     s_blkcnt   = '0;
  logic [asmfs_pkg::POS_W-1:0]       s_poscnt   = '0;

  mapped_byte_t expected_bytes [$];
  int mismatches    = 0;
  int bits_sent     = 0;
  int bits_taken    = 0;
  int idle_cycles   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Depth as the mapper uses it: zero counts as one, large values clip.
  function automatic int eff_depth();
    if (p_depth == 0) return 1;
    if (p_depth > asmfs_pkg::MAX_DEPTH) return asmfs_pkg::MAX_DEPTH;
    return int'(p_depth);
  endfunction

  // Advance the synchronizer by one received bit and say which byte it finishes.
  task automatic sync_and_map_bit(input logic b, output logic produced,
                                  output mapped_byte_t res);
    int   d;
    int   nxt;
    logic last;
    produced = 1'b0;
    res      = '0;
    s_shreg  = {s_shreg[asmfs_pkg::MARKER_BITS-2:0], b};
    if (!s_in_frame) begin
      // Search: sync once the distance to the marker is small enough.
      if ($countones(s_shreg ^ p_pattern[asmfs_pkg::MARKER_BITS-1:0]) <=
          int'(p_max_err)) begin
        s_in_frame = 1'b1;
        s_bitcnt   = '0;
        s_bytecnt  = '0;
        s_blkcnt   = '0;
        s_poscnt   = '0;
      end
    end else begin
      s_bitcnt = s_bitcnt + 3'd1;
      if (s_bitcnt == 0) begin
        d        = eff_depth();
        last     = (int'(s_bytecnt) >= asmfs_pkg::BLOCK_BYTES * d - 1);
        res      = '{s_shreg[7:0], s_blkcnt, s_poscnt, last};
        produced = 1'b1;
        if (p_order) begin
          // Interleaved: byte k goes to block k mod depth.
          nxt = int'(s_blkcnt) + 1;
          if (nxt >= d) begin
            s_blkcnt = '0;
            s_poscnt = s_poscnt + 8'd1;
          end else begin
            s_blkcnt = nxt[asmfs_pkg::BLOCK_W-1:0];
          end
        end else begin
          // Sequential: fill one block before moving to the next.
          nxt = int'(s_poscnt) + 1;
          if (nxt >= asmfs_pkg::BLOCK_BYTES) begin
            s_poscnt = '0;
            s_blkcnt = s_blkcnt + 3'd1;
          end else begin
            s_poscnt = nxt[asmfs_pkg::POS_W-1:0];
          end
        end
        s_bytecnt = s_bytecnt + 11'd1;
        if (last) begin
          s_in_frame = 1'b0;
          s_shreg    = '0;
          s_bitcnt   = '0;
          s_bytecnt  = '0;
          s_blkcnt   = '0;
          s_poscnt   = '0;
        end
      end
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one bit, with an occasional gap before it, and wait for the request to go through.
  task automatic send_bit(input logic b);
    if (tx_idle_on && $urandom_range(0, 99) < 12) begin
      bit_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    bit_ch.valid  <= 1'b1;
    bit_ch.rx_bit <= b;
    do @(posedge clk); while (bit_ch.ready !== 1'b1);
    bits_sent++;
  endtask

  task automatic send_random_bits(input int n);
    repeat (n) send_bit($urandom_range(0, 1));
  endtask

  // Send the marker MSB first with a number of flipped bits.
  task automatic send_marker(input logic [asmfs_pkg::PATTERN_W-1:0] pattern,
                             input int flips);
    logic [asmfs_pkg::PATTERN_W-1:0] m;
    int j;
    m = pattern;
    for (j = 0; j < flips; j++) m[$urandom_range(0, asmfs_pkg::MARKER_BITS - 1)] ^= 1'b1;
    for (j = asmfs_pkg::MARKER_BITS - 1; j >= 0; j--) send_bit(m[j]);
  endtask

  // Stop sending and wait until every expected byte has come back.
  task automatic wait_drained();
    bit_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [asmfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asmfs_pkg::PATTERN_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  // One random piece of stream: a marker with data, a cut-off marker, or noise.
  task automatic random_segment(input logic [asmfs_pkg::PATTERN_W-1:0] pattern,
                                input int maxerr);
    int r;
    int k;
    int kmax;
    int n;
    int j;
    tx_idle_on = ($urandom_range(0, 4) != 0);
    rx_idle_on = ($urandom_range(0, 4) != 0);
    kmax = (maxerr < asmfs_pkg::MARKER_BITS) ? maxerr : asmfs_pkg::MARKER_BITS;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 99) < 80) k = $urandom_range(0, kmax);
      else k = (maxerr < asmfs_pkg::MARKER_BITS) ? maxerr + 1 : asmfs_pkg::MARKER_BITS;
      send_marker(pattern, k);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 12);
      send_random_bits(8 * n);
    end else if (r < 75) begin
      n = $urandom_range(8, asmfs_pkg::MARKER_BITS - 1);
      for (j = asmfs_pkg::MARKER_BITS - 1; j >= asmfs_pkg::MARKER_BITS - n; j--) begin
        send_bit(pattern[j]);
      end
      send_random_bits($urandom_range(1, 16));
    end else begin
      send_random_bits($urandom_range(1, 48));
    end
  endtask

  // Reconfigure with no byte pending, send markers with a drain after each,
  // then a random stream.
  task automatic run_phase(input logic [asmfs_pkg::PATTERN_W-1:0] pattern,
                           input int maxerr, input int depth, input int order,
                           input int frames, input int budget);
    int start;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write(asmfs_pkg::REG_SYNC_PATTERN, pattern);
    cfg_write(asmfs_pkg::REG_MAX_BIT_ERRORS, ($urandom & ~32'h3F) | maxerr);
    cfg_write(asmfs_pkg::REG_INTERLEAVE_DEPTH, ($urandom & ~32'hF) | depth);
    cfg_write(asmfs_pkg::REG_INTERLEAVED_ORDER, ($urandom & ~32'h1) | order);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    repeat (frames) begin
      send_marker(pattern, $urandom_range(0, (maxerr < 3) ? maxerr : 3));
      wait_drained();
    end
    start = bits_sent;
    while (bits_sent - start < budget) random_segment(pattern, maxerr);
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      byte_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      byte_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      byte_ch.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len() - 1;
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= 1'b1;
    end
  end

  // Track every accepted request: config writes, returned bytes and sent bits.
  always @(posedge clk) begin : track
    mapped_byte_t got;
    mapped_byte_t want;
    mapped_byte_t predicted;
    logic         produced;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          asmfs_pkg::REG_SYNC_PATTERN:      p_pattern = cfg_ch.data;
          asmfs_pkg::REG_MAX_BIT_ERRORS:    p_max_err = cfg_ch.data[asmfs_pkg::ERR_W-1:0];
          asmfs_pkg::REG_INTERLEAVE_DEPTH:  p_depth   = cfg_ch.data[asmfs_pkg::DEPTH_W-1:0];
          asmfs_pkg::REG_INTERLEAVED_ORDER: p_order   = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) begin
        got = '{byte_ch.byte_value, byte_ch.block_index, byte_ch.byte_position,
                byte_ch.frame_last};
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with none expected", got.value));
        end else begin
          want = expected_bytes.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("byte_value %02h, expected %02h", got.value, want.value));
          if (got.block !== want.block)
            report_mismatch($sformatf("block_index %0d, expected %0d", got.block, want.block));
          if (got.pos !== want.pos)
            report_mismatch($sformatf("byte_position %0d, expected %0d", got.pos, want.pos));
          if (got.last !== want.last)
            report_mismatch($sformatf("frame_last %0b, expected %0b", got.last, want.last));
        end
      end
      if (bit_ch.valid && bit_ch.ready) begin
        sync_and_map_bit(bit_ch.rx_bit, produced, predicted);
        if (bits_taken < DIR_N && directed_rows[bits_taken].typed) begin
          expected_bytes.push_back(directed_rows[bits_taken].res);
        end else if (produced) begin
          expected_bytes.push_back(predicted);
        end
        bits_taken++;
      end
    end
  end

  // Watchdog: end the run when no request moves for too long.
  always @(posedge clk) begin
    if (rst || (bit_ch.valid && bit_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    rst           = 1'b1;
    bit_ch.valid  = 1'b0;
    bit_ch.rx_bit = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = asmfs_pkg::REG_SYNC_PATTERN;
    cfg_ch.data   = '0;
    byte_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: other registers stay at their reset values.
    cfg_write(asmfs_pkg::REG_SYNC_PATTERN, 32'h0000_0001);
    cfg_ch.valid <= 1'b0;
    for (i = 0; i < DIR_N; i++) send_bit(directed_rows[i].rx);

    // Random part, one configuration per phase; the mapping changes mid-frame.
    run_phase($urandom, 0, 1, 1, 1, 100);

    // Long output hold-off while bits keep coming, then a full drain.
    tx_idle_on = 1'b0;
    hold_requests++;
    send_marker(p_pattern, 0);
    send_random_bits(64);
    wait_drained();
    tx_idle_on = 1'b1;

    run_phase(asmfs_pkg::SYNC_PATTERN_RESET, 3, 0, 0, 1, 60);
    run_phase($urandom, 5, 2, 0, 1, 60);
    run_phase($urandom, 2, 15, 1, 1, 60);
    run_phase($urandom, 1, 8, 0, 0, 60);
    run_phase($urandom, 32, 3, 1, 0, 60);
    run_phase(32'h0000_0000, 63, 4, 0, 0, 60);
    run_phase(32'hFFFF_FFFF, 0, 8, 1, 0, 60);

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0) report_mismatch("expected bytes never arrived");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[asm_frame_sync_deinterleaver.f]
hdl/asmfs_pkg.sv
hdl/asmfs_if.sv
hdl/asmfs_sync_detect.sv
hdl/asmfs_byte_map.sv
hdl/asm_frame_sync_deinterleaver.sv
hdl/asmfs_checker.sv
sim/tb_top.sv
